// ----- sv/rso_pkg.sv -----
// Shared constants, action codes and compare-result type for the range set
// overlap/coverage block. No dependencies.
package rso_pkg;

  localparam int MAX_RANGES_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int TAG_BITS       = 16;
  localparam int ACT_BITS       = 2;

  localparam logic [ACT_BITS-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_CLEAR = 2'd2;

  // Flags from the shared range compare unit.
  typedef struct packed {
    logic overlap;  // [a_lo,a_hi] and [b_lo,b_hi] share a value
    logic join_lo;  // a_hi + 1 == b_lo
    logic join_hi;  // b_hi + 1 == a_lo
  } cmp_res_t;

endpackage

// ----- sv/range_set_overlap_coverage.sv -----
// Range set with overlap check on add and exact-coverage query.
// Depends on rso_pkg, rso_cmp, rso_work_mem.
//
//   channel  direction  handshake            word
//   in       input      in_valid/in_ready    action, range_first, range_last, source_tag
//   out      output     out_valid/out_ready  overlap_found, overlap_tag, spans_exactly,
//                                            table_full
//
// One word in flight; in_ready is high only while the sequencer is idle.
// Add: one stored entry per cycle through the compare unit.
// Query: repeated merge passes, up to n passes for n stored ranges, until a pass
//   joins nothing; clear only resets the count.
// The result sits in an output register; the next word is taken while it waits.
// rst (synchronous) empties the table; stored bounds and tags are not cleared.
module range_set_overlap_coverage import rso_pkg::*; #(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ACT_BITS-1:0]          action,
  input  logic signed [VALUE_BITS-1:0] range_first,
  input  logic signed [VALUE_BITS-1:0] range_last,
  input  logic [TAG_BITS-1:0]          source_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         overlap_found,
  output logic [TAG_BITS-1:0]          overlap_tag,
  output logic                         spans_exactly,
  output logic                         table_full
);

  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_QPASS = 3'd2;
  localparam logic [2:0] S_QCOL  = 3'd3;
  localparam logic [2:0] S_QFIN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] nout, nout_next;
  logic [CW-1:0] ncur, ncur_next;
  logic          joined_any, joined_any_next;
  logic          src_store, src_store_next;
  logic          dst_b, dst_b_next;

  logic signed [VALUE_BITS-1:0] first_q, first_q_next;
  logic signed [VALUE_BITS-1:0] last_q, last_q_next;
  logic [TAG_BITS-1:0]          tag_q, tag_q_next;
  logic signed [VALUE_BITS-1:0] d0_lo, d0_lo_next;
  logic signed [VALUE_BITS-1:0] d0_hi, d0_hi_next;

  logic                res_found, res_found_next;
  logic [TAG_BITS-1:0] res_tag, res_tag_next;
  logic                res_spans, res_spans_next;
  logic                res_full, res_full_next;
  logic                out_valid_next;
  logic                overlap_found_next;
  logic [TAG_BITS-1:0] overlap_tag_next;
  logic                spans_exactly_next;
  logic                table_full_next;

  // range table
  logic signed [VALUE_BITS-1:0] lo_store [MAX_RANGES];
  logic signed [VALUE_BITS-1:0] hi_store [MAX_RANGES];
  logic [TAG_BITS-1:0]          tag_store [MAX_RANGES];
  logic signed [VALUE_BITS-1:0] st_lo, st_hi;
  logic [TAG_BITS-1:0]          st_tag;
  logic                         st_we;

  // merge scratch
  logic                         dst_wr;
  logic [IW-1:0]                dst_waddr;
  logic signed [VALUE_BITS-1:0] dst_wlo, dst_whi;
  logic signed [VALUE_BITS-1:0] a_rlo, a_rhi, b_rlo, b_rhi;
  logic signed [VALUE_BITS-1:0] src_lo, src_hi, dst_lo, dst_hi;

  logic signed [VALUE_BITS-1:0] cmp_a_lo, cmp_a_hi, cmp_b_lo, cmp_b_hi;
  cmp_res_t                     cmp;

  logic row_done, joined, join_tot;

  assign in_ready = (state == S_IDLE);

  assign src_lo = src_store ? st_lo : (dst_b ? a_rlo : b_rlo);
  assign src_hi = src_store ? st_hi : (dst_b ? a_rhi : b_rhi);
  assign dst_lo = dst_b ? b_rlo : a_rlo;
  assign dst_hi = dst_b ? b_rhi : a_rhi;

  // read addresses follow the index values of the next cycle
  always_ff @(posedge clk) begin
    if (st_we) begin
      lo_store[count[IW-1:0]]  <= first_q;
      hi_store[count[IW-1:0]]  <= last_q;
      tag_store[count[IW-1:0]] <= tag_q;
    end
    st_lo  <= lo_store[i_next[IW-1:0]];
    st_hi  <= hi_store[i_next[IW-1:0]];
    st_tag <= tag_store[i_next[IW-1:0]];
  end

  rso_work_mem #(.DEPTH(MAX_RANGES), .VB(VALUE_BITS)) u_mem_a (
    .clk   (clk),
    .we    (dst_wr && !dst_b),
    .waddr (dst_waddr),
    .wlo   (dst_wlo),
    .whi   (dst_whi),
    .raddr (dst_b ? i_next[IW-1:0] : j_next[IW-1:0]),
    .rlo   (a_rlo),
    .rhi   (a_rhi)
  );

  rso_work_mem #(.DEPTH(MAX_RANGES), .VB(VALUE_BITS)) u_mem_b (
    .clk   (clk),
    .we    (dst_wr && dst_b),
    .waddr (dst_waddr),
    .wlo   (dst_wlo),
    .whi   (dst_whi),
    .raddr (dst_b ? j_next[IW-1:0] : i_next[IW-1:0]),
    .rlo   (b_rlo),
    .rhi   (b_rhi)
  );

  assign cmp_a_lo = (state == S_ADD) ? first_q : src_lo;
  assign cmp_a_hi = (state == S_ADD) ? last_q  : src_hi;
  assign cmp_b_lo = (state == S_ADD) ? st_lo   : dst_lo;
  assign cmp_b_hi = (state == S_ADD) ? st_hi   : dst_hi;

  rso_cmp #(.VB(VALUE_BITS)) u_cmp (
    .a_lo (cmp_a_lo),
    .a_hi (cmp_a_hi),
    .b_lo (cmp_b_lo),
    .b_hi (cmp_b_hi),
    .res  (cmp)
  );

  always_comb begin
    state_next         = state;
    count_next         = count;
    i_next             = i;
    j_next             = j;
    nout_next          = nout;
    ncur_next          = ncur;
    joined_any_next    = joined_any;
    src_store_next     = src_store;
    dst_b_next         = dst_b;
    first_q_next       = first_q;
    last_q_next        = last_q;
    tag_q_next         = tag_q;
    d0_lo_next         = d0_lo;
    d0_hi_next         = d0_hi;
    res_found_next     = res_found;
    res_tag_next       = res_tag;
    res_spans_next     = res_spans;
    res_full_next      = res_full;
    out_valid_next     = out_valid && !out_ready;
    overlap_found_next = overlap_found;
    overlap_tag_next   = overlap_tag;
    spans_exactly_next = spans_exactly;
    table_full_next    = table_full;
    st_we              = 1'b0;
    dst_wr             = 1'b0;
    dst_waddr          = j[IW-1:0];
    dst_wlo            = src_lo;
    dst_whi            = src_hi;
    row_done           = 1'b0;
    joined             = 1'b0;
    join_tot           = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          first_q_next   = range_first;
          last_q_next    = range_last;
          tag_q_next     = source_tag;
          i_next         = '0;
          j_next         = '0;
          res_found_next = 1'b0;
          res_tag_next   = '0;
          res_spans_next = 1'b0;
          res_full_next  = 1'b0;
          case (action)
            ACT_ADD: state_next = S_ADD;
            ACT_QUERY: begin
              if (count == '0) begin
                state_next = S_DONE;
              end else begin
                ncur_next       = count;
                nout_next       = '0;
                joined_any_next = 1'b0;
                src_store_next  = 1'b1;
                dst_b_next      = 1'b0;
                state_next      = S_QPASS;
              end
            end
            ACT_CLEAR: begin
              count_next = '0;
              state_next = S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end

      S_ADD: begin
        if (i == count) begin
          if (count >= MAX_CNT) begin
            res_full_next = 1'b1;
          end else begin
            st_we      = 1'b1;
            count_next = count + CW'(1);
          end
          state_next = S_DONE;
        end else if (cmp.overlap) begin
          res_found_next = 1'b1;
          res_tag_next   = st_tag;
          state_next     = S_DONE;
        end else begin
          i_next = i + CW'(1);
        end
      end

      // issues the first reads with the new source/destination roles
      S_QPASS: begin
        i_next     = '0;
        j_next     = '0;
        state_next = S_QCOL;
      end

      S_QCOL: begin
        if (j == nout) begin
          dst_wr    = 1'b1;
          dst_waddr = nout[IW-1:0];
          nout_next = nout + CW'(1);
          row_done  = 1'b1;
        end else if (cmp.join_lo) begin
          dst_wr   = 1'b1;
          dst_wlo  = src_lo;
          dst_whi  = dst_hi;
          joined   = 1'b1;
          row_done = 1'b1;
        end else if (cmp.join_hi) begin
          dst_wr   = 1'b1;
          dst_wlo  = dst_lo;
          dst_whi  = src_hi;
          joined   = 1'b1;
          row_done = 1'b1;
        end else begin
          j_next = j + CW'(1);
        end

        if (dst_wr && (dst_waddr == '0)) begin
          d0_lo_next = dst_wlo;
          d0_hi_next = dst_whi;
        end

        if (row_done) begin
          join_tot        = joined_any || joined;
          j_next          = '0;
          i_next          = i + CW'(1);
          joined_any_next = join_tot;
          if ((i + CW'(1)) == ncur) begin
            if (join_tot) begin
              ncur_next       = nout_next;
              nout_next       = '0;
              joined_any_next = 1'b0;
              src_store_next  = 1'b0;
              dst_b_next      = !dst_b;
              i_next          = '0;
              state_next      = S_QPASS;
            end else begin
              state_next = S_QFIN;
            end
          end
        end
      end

      S_QFIN: begin
        res_spans_next = (nout == CW'(1)) && (d0_lo == first_q) && (d0_hi == last_q);
        state_next     = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next     = 1'b1;
          overlap_found_next = res_found;
          overlap_tag_next   = res_tag;
          spans_exactly_next = res_spans;
          table_full_next    = res_full;
          state_next         = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      i          <= '0;
      j          <= '0;
      nout       <= '0;
      ncur       <= '0;
      joined_any <= 1'b0;
      src_store  <= 1'b1;
      dst_b      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      i          <= i_next;
      j          <= j_next;
      nout       <= nout_next;
      ncur       <= ncur_next;
      joined_any <= joined_any_next;
      src_store  <= src_store_next;
      dst_b      <= dst_b_next;
      out_valid  <= out_valid_next;
    end
    first_q       <= first_q_next;
    last_q        <= last_q_next;
    tag_q         <= tag_q_next;
    d0_lo         <= d0_lo_next;
    d0_hi         <= d0_hi_next;
    res_found     <= res_found_next;
    res_tag       <= res_tag_next;
    res_spans     <= res_spans_next;
    res_full      <= res_full_next;
    overlap_found <= overlap_found_next;
    overlap_tag   <= overlap_tag_next;
    spans_exactly <= spans_exactly_next;
    table_full    <= table_full_next;
  end

  // merged list never grows faster than rows consumed
  a_nout_le_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_QCOL) |-> ((nout <= i) && (j <= nout)))
    else $error("merge output count ahead of row index");

  a_ncur_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_QCOL) || (state == S_QPASS)) |-> ((ncur <= count) && (ncur != '0)))
    else $error("merge pass length out of bounds");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (action == ACT_CLEAR)) |=> (count == '0))
    else $error("clear did not empty the table");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |-> ((count <= MAX_CNT) && (i <= count)))
    else $error("add scan index past table fill");

  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!(table_full && overlap_found) &&
                   !(spans_exactly && (table_full || overlap_found))))
    else $error("result flags from different actions both set");

endmodule

// ----- sv/rso_cmp.sv -----
// Shared range compare unit: overlap test and adjacency tests on two ranges.
// Depends on rso_pkg.
module rso_cmp import rso_pkg::*; #(
  parameter int VB = VALUE_BITS_DEF
) (
  input  logic signed [VB-1:0] a_lo,
  input  logic signed [VB-1:0] a_hi,
  input  logic signed [VB-1:0] b_lo,
  input  logic signed [VB-1:0] b_hi,
  output cmp_res_t             res
);

  // one extra bit so that x + 1 never wraps at the top of the range
  logic signed [VB:0] a_hi_p1;
  logic signed [VB:0] b_hi_p1;

  assign a_hi_p1 = {a_hi[VB-1], a_hi} + (VB+1)'(1);
  assign b_hi_p1 = {b_hi[VB-1], b_hi} + (VB+1)'(1);

  assign res.overlap = (a_lo <= b_hi) && (a_hi >= b_lo);
  assign res.join_lo = (a_hi_p1 == {b_lo[VB-1], b_lo});
  assign res.join_hi = (b_hi_p1 == {a_lo[VB-1], a_lo});

endmodule

// ----- sv/rso_work_mem.sv -----
// Merge scratch memory: one write port, one registered read port,
// write-first on an address collision. Depends on rso_pkg.
module rso_work_mem import rso_pkg::*; #(
  parameter int DEPTH = MAX_RANGES_DEF,
  parameter int VB    = VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic signed [VB-1:0]     wlo,
  input  logic signed [VB-1:0]     whi,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic signed [VB-1:0]     rlo,
  output logic signed [VB-1:0]     rhi
);

  logic signed [VB-1:0] lo_mem [DEPTH];
  logic signed [VB-1:0] hi_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      lo_mem[waddr] <= wlo;
      hi_mem[waddr] <= whi;
    end
    if (we && (waddr == raddr)) begin
      rlo <= wlo;
      rhi <= whi;
    end else begin
      rlo <= lo_mem[raddr];
      rhi <= hi_mem[raddr];
    end
  end

endmodule
